@@ rtl/fm_channel_pitch_register_writer_assert.svh @@
// assertion macros for the fm channel pitch register writer
`ifndef FM_CHANNEL_PITCH_REGISTER_WRITER_ASSERT_SVH
`define FM_CHANNEL_PITCH_REGISTER_WRITER_ASSERT_SVH

// same-cycle implication, checked on clk and masked during reset
`define FMPW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmpw check failed");

// next-cycle implication, checked on clk and masked during reset
`define FMPW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmpw check failed");

`endif

@@ rtl/fmpw_pkg.sv @@
// shared types, constants and functions for the fm channel pitch register writer
`default_nettype none

package fmpw_pkg;

    // request codes
    localparam logic [2:0] REQ_RAW        = 3'd0;
    localparam logic [2:0] REQ_FORCE      = 3'd1;
    localparam logic [2:0] REQ_NOTE_ON    = 3'd2;
    localparam logic [2:0] REQ_NOTE_OFF   = 3'd3;
    localparam logic [2:0] REQ_SET_PITCH  = 3'd4;
    localparam logic [2:0] REQ_FINE_PITCH = 3'd5;
    localparam logic [2:0] REQ_DETUNED_ON = 3'd6;

    // configuration register indexes
    localparam logic CFG_DRUM_MASK   = 1'b0;
    localparam logic CFG_EXPORT_MODE = 1'b1;

    // synth register map
    localparam logic [7:0] REG_FLO      = 8'hA0;
    localparam logic [7:0] REG_KEY      = 8'hB0;
    localparam logic [7:0] REG_KEY_LAST = 8'hB8;
    localparam logic [7:0] SHADOW_RESET = 8'hFF;
    localparam int         SHADOW_DEPTH = 256;

    localparam logic [5:0] KEY_BIT   = 6'h20;
    localparam logic [5:0] KEY_MASK  = 6'h1F;
    localparam logic [7:0] NOTE_MIN  = 8'd12;
    localparam logic [7:0] NOTE_MAX  = 8'd127;
    localparam logic [7:0] DRUM_NOTE = 8'd60;
    localparam logic [9:0] FNUM_MAX  = 10'd1023;

    // reciprocal of 554, exact for magnitudes below 2^24
    localparam logic [24:0] DETUNE_RECIP = 25'd31010595;
    localparam int          DETUNE_SHIFT = 34;

    // item after the note lookup stage
    typedef struct packed {
        logic [2:0]         req_type;
        logic [3:0]         channel;
        logic signed [7:0]  offset;
        logic [7:0]         wr_addr;
        logic [7:0]         wr_data;
        logic [9:0]         fnum;
        logic [2:0]         blk;
        logic [16:0]        v;
        logic signed [25:0] prod;
    } freq_t;

    // up to two register writes of one request
    typedef struct packed {
        logic       en0;
        logic [7:0] a0;
        logic [7:0] d0;
        logic       en1;
        logic [7:0] a1;
        logic [7:0] d1;
        logic       frc;
    } wpair_t;

    // f-number of a semitone within the octave
    function automatic logic [9:0] fnum_lookup(input logic [3:0] semi);
        logic [9:0] f;
        case (semi)
            4'd0:    f = 10'd345;
            4'd1:    f = 10'd365;
            4'd2:    f = 10'd387;
            4'd3:    f = 10'd410;
            4'd4:    f = 10'd435;
            4'd5:    f = 10'd460;
            4'd6:    f = 10'd488;
            4'd7:    f = 10'd517;
            4'd8:    f = 10'd547;
            4'd9:    f = 10'd580;
            4'd10:   f = 10'd615;
            4'd11:   f = 10'd651;
            default: f = 10'd0;
        endcase
        return f;
    endfunction

    // idx / 12 for idx below 120, by reciprocal multiply
    function automatic logic [3:0] octave_of(input logic [6:0] idx);
        logic [12:0] p;
        p = 13'(idx) * 13'd43;
        return p[12:9];
    endfunction

    // block and f-number high bits of a key register byte
    function automatic logic [4:0] key_byte(input logic [2:0] blk, input logic [9:0] fnum);
        return {blk, fnum[9:8]};
    endfunction

endpackage

`default_nettype wire

@@ rtl/fmpw_freq.sv @@
// input register and note to block / f-number lookup with detune product
`default_nettype none

module fmpw_freq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          req_type,
    input  wire logic [3:0]          channel,
    input  wire logic [7:0]          note,
    input  wire logic signed [7:0]   offset,
    input  wire logic [7:0]          in_reg,
    input  wire logic [7:0]          in_data,
    input  wire logic [8:0]          drum_mask,
    output logic                     freq_valid,
    input  wire logic                freq_ready,
    output fmpw_pkg::freq_t          freq
);

    logic               v1_reg;
    logic [2:0]         type_reg;
    logic [3:0]         ch_reg;
    logic [7:0]         note_reg;
    logic signed [7:0]  off_reg;
    logic [7:0]         addr_reg;
    logic [7:0]         data_reg;

    logic [15:0] drum_vec;
    logic        drum;
    logic [7:0]  n;
    logic [6:0]  nc;
    logic [6:0]  idx;
    logic [3:0]  oct;
    logic [6:0]  rem;
    logic [2:0]  blk;
    logic [9:0]  fnum;
    logic [16:0] v;

    assign in_ready   = !v1_reg || freq_ready;
    assign freq_valid = v1_reg;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v1_reg <= in_valid;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            type_reg <= req_type;
            ch_reg   <= channel;
            note_reg <= note;
            off_reg  <= offset;
            addr_reg <= in_reg;
            data_reg <= in_data;
        end
    end

    // drum override and note clamp
    assign drum_vec = {7'b0, drum_mask};
    assign drum     = drum_vec[ch_reg];

    always_comb
    begin
        if (drum && (type_reg == fmpw_pkg::REQ_NOTE_ON || type_reg == fmpw_pkg::REQ_SET_PITCH
                     || type_reg == fmpw_pkg::REQ_DETUNED_ON))
        begin
            n = fmpw_pkg::DRUM_NOTE;
        end
        else
        begin
            n = note_reg;
        end
        if (n < fmpw_pkg::NOTE_MIN)
        begin
            nc = fmpw_pkg::NOTE_MIN[6:0];
        end
        else if (n > fmpw_pkg::NOTE_MAX)
        begin
            nc = fmpw_pkg::NOTE_MAX[6:0];
        end
        else
        begin
            nc = n[6:0];
        end
    end

    // octave split and table lookup
    assign idx  = nc - fmpw_pkg::NOTE_MIN[6:0];
    assign oct  = fmpw_pkg::octave_of(idx);
    assign rem  = idx - (7'({oct, 3'b000}) + 7'({oct, 2'b00}));
    assign blk  = (oct > 4'd7) ? 3'd7 : oct[2:0];
    assign fnum = fmpw_pkg::fnum_lookup(rem[3:0]);
    assign v    = 17'(fnum) << blk;

    // detune product and outgoing item
    always_comb
    begin
        freq.req_type = type_reg;
        freq.channel  = ch_reg;
        freq.offset   = off_reg;
        freq.wr_addr  = addr_reg;
        freq.wr_data  = data_reg;
        freq.fnum     = fnum;
        freq.blk      = blk;
        freq.v        = v;
        freq.prod     = $signed({1'b0, v}) * off_reg;
    end

endmodule

`default_nettype wire

@@ rtl/fmpw_cmd.sv @@
// detune divide, pitch clamps, key shadow and register write pair builder
`default_nettype none

module fmpw_cmd #(
    parameter int NUM_CHANNELS = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             freq_valid,
    output logic                  freq_ready,
    input  wire fmpw_pkg::freq_t  freq,
    output logic                  pair_valid,
    input  wire logic             pair_ready,
    output fmpw_pkg::wpair_t      pair
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic            v2_reg;
    fmpw_pkg::freq_t f_reg;
    logic [5:0]      key_reg [NUM_CHANNELS];

    logic               cv;
    logic [CH_W-1:0]    ch_idx;
    logic [5:0]         ks;
    logic [23:0]        mag;
    logic [48:0]        qprod;
    logic [14:0]        q;
    logic [18:0]        vn;
    logic [16:0]        vf;
    logic [2:0]         nb;
    logic [16:0]        nf_full;
    logic [9:0]         nf;
    logic signed [11:0] fa_full;
    logic [9:0]         fa;
    logic [7:0]         a_flo;
    logic [7:0]         a_key;
    logic [5:0]         kb;
    logic               ks_wr;

    assign freq_ready = !v2_reg || pair_ready;
    assign pair_valid = v2_reg;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (freq_ready)
        begin
            v2_reg <= freq_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (freq_valid && freq_ready)
        begin
            f_reg <= freq;
        end
    end

    // channel check and key shadow read
    assign cv     = f_reg.channel < 4'(NUM_CHANNELS);
    assign ch_idx = f_reg.channel[CH_W-1:0];
    assign ks     = cv ? key_reg[ch_idx] : 6'd0;
    assign a_flo  = fmpw_pkg::REG_FLO + 8'(f_reg.channel);
    assign a_key  = fmpw_pkg::REG_KEY + 8'(f_reg.channel);

    // detune: v + v*offset/554, truncated toward zero
    assign mag   = f_reg.prod[25] ? 24'(-f_reg.prod) : 24'(f_reg.prod);
    assign qprod = 49'(mag) * 49'(fmpw_pkg::DETUNE_RECIP);
    assign q     = qprod[fmpw_pkg::DETUNE_SHIFT +: 15];
    assign vn    = f_reg.prod[25] ? (19'(f_reg.v) - 19'(q)) : (19'(f_reg.v) + 19'(q));

    // floor at one and renormalize to the lowest fitting block
    always_comb
    begin
        if (vn[18] || vn == 19'd0)
        begin
            vf = 17'd1;
        end
        else
        begin
            vf = vn[16:0];
        end
        nb = 3'd7;
        for (int i = 6; i >= 0; i--)
        begin
            if ((vf >> i) <= 17'(fmpw_pkg::FNUM_MAX))
            begin
                nb = 3'(i);
            end
        end
        nf_full = vf >> nb;
        nf = (nf_full > 17'(fmpw_pkg::FNUM_MAX)) ? fmpw_pkg::FNUM_MAX : nf_full[9:0];
    end

    // fine pitch clamp to 1..1023
    always_comb
    begin
        fa_full = $signed({2'b00, f_reg.fnum}) + 12'($signed(f_reg.offset) <<< 2);
        if (fa_full < 12'sd1)
        begin
            fa = 10'd1;
        end
        else if (fa_full > 12'sd1023)
        begin
            fa = fmpw_pkg::FNUM_MAX;
        end
        else
        begin
            fa = fa_full[9:0];
        end
    end

    // write pair decoder
    always_comb
    begin
        pair  = '0;
        kb    = 6'd0;
        ks_wr = 1'b0;
        unique case (f_reg.req_type)
            fmpw_pkg::REQ_RAW:
            begin
                pair.en0 = 1'b1;
                pair.a0  = f_reg.wr_addr;
                pair.d0  = f_reg.wr_data;
            end
            fmpw_pkg::REQ_FORCE:
            begin
                pair.en0 = 1'b1;
                pair.a0  = f_reg.wr_addr;
                pair.d0  = f_reg.wr_data;
                pair.frc = 1'b1;
            end
            fmpw_pkg::REQ_NOTE_ON:
            begin
                kb       = fmpw_pkg::KEY_BIT | 6'(fmpw_pkg::key_byte(f_reg.blk, f_reg.fnum));
                pair.en0 = cv;
                pair.a0  = a_flo;
                pair.d0  = f_reg.fnum[7:0];
                pair.en1 = cv;
                pair.a1  = a_key;
                pair.d1  = 8'(kb);
                ks_wr    = cv;
            end
            fmpw_pkg::REQ_NOTE_OFF:
            begin
                kb       = ks & fmpw_pkg::KEY_MASK;
                pair.en0 = cv;
                pair.a0  = a_key;
                pair.d0  = 8'(kb);
                ks_wr    = cv;
            end
            fmpw_pkg::REQ_SET_PITCH:
            begin
                kb       = 6'(fmpw_pkg::key_byte(f_reg.blk, f_reg.fnum))
                           | (ks & fmpw_pkg::KEY_BIT);
                pair.en0 = cv;
                pair.a0  = a_flo;
                pair.d0  = f_reg.fnum[7:0];
                pair.en1 = cv;
                pair.a1  = a_key;
                pair.d1  = 8'(kb);
                ks_wr    = cv;
            end
            fmpw_pkg::REQ_FINE_PITCH:
            begin
                kb       = 6'(fmpw_pkg::key_byte(f_reg.blk, fa));
                pair.en0 = cv;
                pair.a0  = a_flo;
                pair.d0  = fa[7:0];
                pair.en1 = cv;
                pair.a1  = a_key;
                pair.d1  = 8'(kb | fmpw_pkg::KEY_BIT);
                ks_wr    = cv;
            end
            fmpw_pkg::REQ_DETUNED_ON:
            begin
                kb       = 6'(fmpw_pkg::key_byte(nb, nf));
                pair.en0 = cv;
                pair.a0  = a_flo;
                pair.d0  = nf[7:0];
                pair.en1 = cv;
                pair.a1  = a_key;
                pair.d1  = 8'(kb | fmpw_pkg::KEY_BIT);
                ks_wr    = cv;
            end
            default:
            begin
                ks_wr = 1'b0;
            end
        endcase
    end

    // key/block shadow update as the pair leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                key_reg[i] <= 6'd0;
            end
        end
        else if (v2_reg && pair_ready && ks_wr)
        begin
            key_reg[ch_idx] <= kb;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fmpw_wshadow.sv @@
// write shadow memory, redundancy filter and serial result register
`default_nettype none

module fmpw_wshadow (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              export_mode,
    input  wire logic              pair_valid,
    output logic                   pair_ready,
    input  wire fmpw_pkg::wpair_t  pair,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_reg,
    output logic [7:0]             out_data,
    output logic                   last_write
);

    logic [7:0] shadow_mem_reg [fmpw_pkg::SHADOW_DEPTH];
    logic [fmpw_pkg::SHADOW_DEPTH-1:0] vld_reg;

    logic             r_v_reg;
    logic             ph_reg;
    fmpw_pkg::wpair_t r_pair_reg;
    logic [7:0]       mq0_reg;
    logic [7:0]       mq1_reg;
    logic             vq0_reg;
    logic             vq1_reg;
    logic             fwd_v_reg;
    logic [7:0]       fwd_a_reg;
    logic [7:0]       fwd_d_reg;
    logic             out_valid_reg;
    logic [7:0]       out_addr_reg;
    logic [7:0]       out_data_reg;
    logic             out_last_reg;

    logic       exp0;
    logic       exp1;
    logic [7:0] s0;
    logic [7:0] s1;
    logic       pass0;
    logic       pass1;
    logic       emit0;
    logic       emit1;
    logic       out_free;
    logic       fire;
    logic       sel_last;
    logic       finish;
    logic       load;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;

    // current shadow contents, with the write made at load time forwarded
    assign s0 = (fwd_v_reg && fwd_a_reg == r_pair_reg.a0) ? fwd_d_reg :
                (vq0_reg ? mq0_reg : fmpw_pkg::SHADOW_RESET);
    assign s1 = (fwd_v_reg && fwd_a_reg == r_pair_reg.a1) ? fwd_d_reg :
                (vq1_reg ? mq1_reg : fmpw_pkg::SHADOW_RESET);

    // key registers bypass the check in export mode
    assign exp0 = export_mode && r_pair_reg.a0 >= fmpw_pkg::REG_KEY
                  && r_pair_reg.a0 <= fmpw_pkg::REG_KEY_LAST;
    assign exp1 = export_mode && r_pair_reg.a1 >= fmpw_pkg::REG_KEY
                  && r_pair_reg.a1 <= fmpw_pkg::REG_KEY_LAST;

    assign pass0 = r_pair_reg.en0 && (r_pair_reg.frc || exp0 || s0 != r_pair_reg.d0);
    assign pass1 = r_pair_reg.en1 && (r_pair_reg.frc || exp1 || s1 != r_pair_reg.d1);

    // pick the next surviving write of the request
    assign emit0    = r_v_reg && !ph_reg && pass0;
    assign emit1    = r_v_reg && !emit0 && pass1;
    assign sel_last = emit0 ? !pass1 : 1'b1;
    assign wr_addr  = emit0 ? r_pair_reg.a0 : r_pair_reg.a1;
    assign wr_data  = emit0 ? r_pair_reg.d0 : r_pair_reg.d1;
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = (emit0 || emit1) && out_free;
    assign finish   = r_v_reg && ((emit0 || emit1) ? (fire && sel_last) : 1'b1);
    assign pair_ready = !r_v_reg || finish;
    assign load     = pair_valid && pair_ready;

    assign out_valid  = out_valid_reg;
    assign out_reg    = out_addr_reg;
    assign out_data   = out_data_reg;
    assign last_write = out_last_reg;

    // shadow memory: one write port, two registered reads
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            shadow_mem_reg[wr_addr] <= wr_data;
        end
        if (load)
        begin
            mq0_reg <= shadow_mem_reg[pair.a0];
            mq1_reg <= shadow_mem_reg[pair.a1];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            r_v_reg       <= 1'b0;
            ph_reg        <= 1'b0;
            fwd_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (load)
            begin
                r_v_reg   <= 1'b1;
                fwd_v_reg <= fire;
            end
            else if (finish)
            begin
                r_v_reg <= 1'b0;
            end
            if (load || finish)
            begin
                ph_reg <= 1'b0;
            end
            else if (fire)
            begin
                ph_reg <= 1'b1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r_pair_reg <= pair;
            vq0_reg    <= vld_reg[pair.a0];
            vq1_reg    <= vld_reg[pair.a1];
            fwd_a_reg  <= wr_addr;
            fwd_d_reg  <= wr_data;
        end
        if (fire)
        begin
            out_addr_reg <= wr_addr;
            out_data_reg <= wr_data;
            out_last_reg <= sel_last;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fm_channel_pitch_register_writer.sv @@
// top level of the fm channel pitch register writer
// Usage:
//   Request channel (in_valid/in_ready) carries one note command: raw or
//   forced register write, note on/off, set pitch, fine pitch or detuned
//   note on. Result channel (out_valid/out_ready) carries register writes
//   (out_reg, out_data); last_write marks the final write of a request.
//   A request gives zero, one or two writes; writes equal to the shadowed
//   byte are dropped unless forced or, in export mode, to a key register.
//   Configuration: cfg_we with cfg_index 0 writes drum_mask, 1 export_mode.
// Each write passes the input, pair, shadow request and result registers.
// Throughput: one request per cycle when it yields at most one write and
//   the receiver does not stall; a request with two writes holds the shadow
//   stage until both leave. Set by the single write port of the 256-byte
//   shadow memory and the one-write-per-cycle result register.
// Reset clears the pipeline, the key/block shadows and the shadow valid
//   bits (all shadow bytes read as 0xFF), and the configuration registers.
// A stalled receiver holds the result register; up to three requests stay
//   buffered in the pipeline before in_ready drops.
`default_nettype none

module fm_channel_pitch_register_writer #(
    parameter int NUM_CHANNELS = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [8:0]        cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        req_type,
    input  wire logic [3:0]        channel,
    input  wire logic [7:0]        note,
    input  wire logic signed [7:0] offset,
    input  wire logic [7:0]        in_reg,
    input  wire logic [7:0]        in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_reg,
    output logic [7:0]             out_data,
    output logic                   last_write
);

`include "fm_channel_pitch_register_writer_assert.svh"

    logic [8:0] drum_mask_reg;
    logic       export_mode_reg;

    logic             freq_valid;
    logic             freq_ready;
    fmpw_pkg::freq_t  freq;
    logic             pair_valid;
    logic             pair_ready;
    fmpw_pkg::wpair_t pair;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drum_mask_reg   <= 9'd0;
            export_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fmpw_pkg::CFG_DRUM_MASK:   drum_mask_reg   <= cfg_wdata;
                fmpw_pkg::CFG_EXPORT_MODE: export_mode_reg <= cfg_wdata[0];
                default:                   export_mode_reg <= export_mode_reg;
            endcase
        end
    end

    // note lookup stage
    fmpw_freq u_freq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .channel    (channel),
        .note       (note),
        .offset     (offset),
        .in_reg     (in_reg),
        .in_data    (in_data),
        .drum_mask  (drum_mask_reg),
        .freq_valid (freq_valid),
        .freq_ready (freq_ready),
        .freq       (freq)
    );

    // write pair builder
    fmpw_cmd #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_cmd (
        .clk        (clk),
        .rst_n      (rst_n),
        .freq_valid (freq_valid),
        .freq_ready (freq_ready),
        .freq       (freq),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair)
    );

    // write shadow and result register
    fmpw_wshadow u_wshadow (
        .clk         (clk),
        .rst_n       (rst_n),
        .export_mode (export_mode_reg),
        .pair_valid  (pair_valid),
        .pair_ready  (pair_ready),
        .pair        (pair),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_reg     (out_reg),
        .out_data    (out_data),
        .last_write  (last_write)
    );

    // a non-final write is always the f-number low byte of a voice
    `FMPW_ASSERT_IMP(a_first_is_flo, out_valid && !last_write, out_reg >= fmpw_pkg::REG_FLO && out_reg <= fmpw_pkg::REG_FLO + 8'd8)

    // the key write of the same voice follows right behind it
    `FMPW_ASSERT_NEXT(a_key_follows, out_valid && out_ready && !last_write, out_valid && last_write && out_reg == $past(out_reg) + 8'h10)

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for the fm channel pitch register writer
`timescale 1ns / 1ps

module tb;

    // request type that no command uses
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0] rtype;
        logic [3:0] ch;
        logic [7:0] nt;
        logic [7:0] ofs;
        logic [7:0] rg;
        logic [7:0] dt;
    } request_t;

    typedef struct packed {
        logic [7:0] rg;
        logic [7:0] dt;
        logic       lst;
    } reg_write_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [8:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic [2:0] req_type;
    logic [3:0] channel;
    logic [7:0] note;
    logic signed [7:0] offset;
    logic [7:0] in_reg;
    logic [7:0] in_data;
    logic out_valid;
    logic out_ready;
    logic [7:0] out_reg;
    logic [7:0] out_data;
    logic last_write;

    fm_channel_pitch_register_writer u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .channel(channel), .note(note), .offset(offset),
        .in_reg(in_reg), .in_data(in_data), .out_valid(out_valid),
        .out_ready(out_ready), .out_reg(out_reg), .out_data(out_data),
        .last_write(last_write)
    );

    // predictor state
    logic [7:0] shadow_mem [fmpw_pkg::SHADOW_DEPTH];
    logic [5:0] key_shadow [9];
    logic [8:0] drum_bits;
    logic       export_on;

    request_t   pending_q[$];
    reg_write_t expected_writes[$];
    reg_write_t step_writes[$];

    int  error_count;
    int  idle_cycles;
    bit  calm;          // no idling in the last part
    bit  hold_request;  // long receiver hold-off
    int  hold_count;
    int  in_gap;
    int  out_gap;
    bit  in_acc;        // request taken at the last rising edge

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one write through the shadow check
    task automatic shadow_write(input logic [7:0] a, input logic [7:0] d, input bit frc);
        bit keyreg;
        reg_write_t w;
        keyreg = (a >= fmpw_pkg::REG_KEY) && (a <= fmpw_pkg::REG_KEY_LAST);
        if (!(frc || (export_on && keyreg)) && shadow_mem[a] == d)
            return;
        shadow_mem[a] = d;
        w.rg = a;
        w.dt = d;
        w.lst = 1'b0;
        step_writes.push_back(w);
    endtask

    // f-number and block of a clamped note
    task automatic pitch_of(input logic [7:0] n, output int fn, output int bl);
        int m;
        m = n;
        if (m < 12) m = 12;
        if (m > 127) m = 127;
        bl = (m - 12) / 12;
        if (bl > 7) bl = 7;
        case ((m - 12) % 12)
            0: fn = 345;  1: fn = 365;  2: fn = 387;  3: fn = 410;
            4: fn = 435;  5: fn = 460;  6: fn = 488;  7: fn = 517;
            8: fn = 547;  9: fn = 580;  10: fn = 615; default: fn = 651;
        endcase
    endtask

    // expected writes of one accepted request
    task automatic predict_writes(input request_t r);
        logic [7:0] n;
        logic [5:0] kb;
        logic [7:0] ca;
        logic [7:0] ka;
        int fn, bl, a, v, vn, nb, nf, so;
        reg_write_t w;
        step_writes.delete();
        so = $signed(r.ofs);
        ca = fmpw_pkg::REG_FLO + 8'(r.ch);
        ka = fmpw_pkg::REG_KEY + 8'(r.ch);
        if (r.rtype == fmpw_pkg::REQ_RAW)
            shadow_write(r.rg, r.dt, 1'b0);
        else if (r.rtype == fmpw_pkg::REQ_FORCE)
            shadow_write(r.rg, r.dt, 1'b1);
        else if (r.rtype <= fmpw_pkg::REQ_DETUNED_ON && r.ch < 9)
        begin
            n = r.nt;
            if (drum_bits[r.ch] && (r.rtype == fmpw_pkg::REQ_NOTE_ON
                    || r.rtype == fmpw_pkg::REQ_SET_PITCH
                    || r.rtype == fmpw_pkg::REQ_DETUNED_ON))
                n = fmpw_pkg::DRUM_NOTE;
            pitch_of(n, fn, bl);
            case (r.rtype)
                fmpw_pkg::REQ_NOTE_ON:
                begin
                    kb = {1'b1, 3'(bl), 2'(fn >> 8)};
                    shadow_write(ca, 8'(fn), 1'b0);
                    shadow_write(ka, {2'b00, kb}, 1'b0);
                    key_shadow[r.ch] = kb;
                end
                fmpw_pkg::REQ_NOTE_OFF:
                begin
                    kb = key_shadow[r.ch] & fmpw_pkg::KEY_MASK;
                    shadow_write(ka, {2'b00, kb}, 1'b0);
                    key_shadow[r.ch] = kb;
                end
                fmpw_pkg::REQ_SET_PITCH:
                begin
                    kb = {key_shadow[r.ch][5], 3'(bl), 2'(fn >> 8)};
                    shadow_write(ca, 8'(fn), 1'b0);
                    shadow_write(ka, {2'b00, kb}, 1'b0);
                    key_shadow[r.ch] = kb;
                end
                fmpw_pkg::REQ_FINE_PITCH:
                begin
                    a = fn + so * 4;
                    if (a < 1) a = 1;
                    if (a > 1023) a = 1023;
                    kb = {1'b1, 3'(bl), 2'(a >> 8)};
                    shadow_write(ca, 8'(a), 1'b0);
                    shadow_write(ka, {2'b00, kb}, 1'b0);
                    key_shadow[r.ch] = kb & fmpw_pkg::KEY_MASK;
                end
                default:
                begin
                    v = fn << bl;
                    vn = v + (v * so) / 554;
                    if (vn < 1) vn = 1;
                    nb = 0;
                    while ((vn >> nb) > 1023 && nb < 7) nb++;
                    nf = vn >> nb;
                    if (nf > 1023) nf = 1023;
                    kb = {1'b1, 3'(nb), 2'(nf >> 8)};
                    shadow_write(ca, 8'(nf), 1'b0);
                    shadow_write(ka, {2'b00, kb}, 1'b0);
                    key_shadow[r.ch] = kb & fmpw_pkg::KEY_MASK;
                end
            endcase
        end
        if (step_writes.size() > 0)
            step_writes[step_writes.size() - 1].lst = 1'b1;
        foreach (step_writes[i])
        begin
            w = step_writes[i];
            expected_writes.push_back(w);
        end
    endtask

    // driver: payload and valid change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_acc)
                ;
            else if (!calm && in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                if (!calm && $urandom_range(0, 9) == 0)
                begin
                    in_gap <= $urandom_range(1, 16);
                    in_valid <= 1'b0;
                end
                else
                begin
                    req_type <= pending_q[0].rtype;
                    channel <= pending_q[0].ch;
                    note <= pending_q[0].nt;
                    offset <= pending_q[0].ofs;
                    in_reg <= pending_q[0].rg;
                    in_data <= pending_q[0].dt;
                    in_valid <= 1'b1;
                    void'(pending_q.pop_front());
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request && hold_count < 200)
            begin
                hold_count <= hold_count + 1;
                out_ready <= 1'b0;
            end
            else if (!calm && out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_gap <= $urandom_range(1, 16);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: requests into the predictor, results against expectations
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_acc <= in_valid && in_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && in_ready)
            begin
                request_t r;
                r = {req_type, channel, note, offset, in_reg, in_data};
                predict_writes(r);
            end
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected write reg=%h data=%h", out_reg, out_data);
                    error_count++;
                end
                else
                begin
                    reg_write_t e;
                    e = expected_writes.pop_front();
                    if (out_reg !== e.rg)
                    begin
                        $error("out_reg expected %h actual %h", e.rg, out_reg);
                        error_count++;
                    end
                    if (out_data !== e.dt)
                    begin
                        $error("out_data expected %h actual %h", e.dt, out_data);
                        error_count++;
                    end
                    if (last_write !== e.lst)
                    begin
                        $error("last_write expected %b actual %b", e.lst, last_write);
                        error_count++;
                    end
                end
            end
            if (idle_cycles > 5000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic request_t make_req(input logic [2:0] t, input logic [3:0] c,
                                          input logic [7:0] n, input logic [7:0] o);
        request_t r;
        r.rtype = t;
        r.ch = c;
        r.nt = n;
        r.ofs = o;
        r.rg = 8'($urandom);
        r.dt = 8'($urandom);
        return r;
    endfunction

    // random request, mostly note commands on valid channels
    function automatic request_t rand_req();
        request_t r;
        int k;
        k = $urandom_range(0, 99);
        r = make_req(3'($urandom_range(2, 6)), 4'($urandom_range(0, 8)),
                     8'($urandom), 8'($urandom));
        if (k < 8)
            r.ch = 4'($urandom_range(9, 15));
        else if (k < 11)
            r.rtype = REQ_UNUSED;
        else if (k < 25)
        begin
            r.rtype = ($urandom_range(0, 1) != 0) ? fmpw_pkg::REQ_RAW : fmpw_pkg::REQ_FORCE;
            // favor the synth key and pitch registers to collide with notes
            if ($urandom_range(0, 1) != 0)
                r.rg = 8'($urandom_range(8'hA0, 8'hB8));
            r.ch = 4'($urandom);
        end
        else if (k < 45)
            r.nt = 8'($urandom_range(0, 140));
        return r;
    endfunction

    task automatic wait_drain();
        while (pending_q.size() > 0 || in_valid || expected_writes.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_config(input logic idx, input logic [8:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == fmpw_pkg::CFG_DRUM_MASK)
            drum_bits = val;
        else
            export_on = val[0];
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        req_type = '0;
        channel = '0;
        note = '0;
        offset = '0;
        in_reg = '0;
        in_data = '0;
        error_count = 0;
        idle_cycles = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        hold_count = 0;
        in_gap = 0;
        out_gap = 0;
        in_acc = 1'b0;
        drum_bits = '0;
        export_on = 1'b0;
        for (int i = 0; i < fmpw_pkg::SHADOW_DEPTH; i++) shadow_mem[i] = fmpw_pkg::SHADOW_RESET;
        for (int i = 0; i < 9; i++) key_shadow[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, every request type, clamps and drop cases
        pending_q.push_back(make_req(fmpw_pkg::REQ_NOTE_ON, 4'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_NOTE_ON, 4'd0, 8'd0, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_NOTE_ON, 4'd8, 8'd255, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_NOTE_OFF, 4'd8, 8'd0, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_NOTE_OFF, 4'd8, 8'd0, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_SET_PITCH, 4'd3, 8'd127, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_FINE_PITCH, 4'd1, 8'd12, 8'h80));
        pending_q.push_back(make_req(fmpw_pkg::REQ_FINE_PITCH, 4'd1, 8'd127, 8'h7F));
        pending_q.push_back(make_req(fmpw_pkg::REQ_DETUNED_ON, 4'd2, 8'd127, 8'h7F));
        pending_q.push_back(make_req(fmpw_pkg::REQ_DETUNED_ON, 4'd2, 8'd12, 8'h80));
        pending_q.push_back(make_req(fmpw_pkg::REQ_DETUNED_ON, 4'd4, 8'd60, 8'h00));
        pending_q.push_back(make_req(fmpw_pkg::REQ_NOTE_ON, 4'd9, 8'd60, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_NOTE_ON, 4'd15, 8'd60, 8'd0));
        pending_q.push_back(make_req(REQ_UNUSED, 4'd0, 8'd60, 8'd0));
        begin
            request_t r;
            r = make_req(fmpw_pkg::REQ_RAW, 4'd0, 8'd0, 8'd0);
            r.rg = 8'h00; r.dt = 8'hFF;   // equals reset shadow, dropped
            pending_q.push_back(r);
            r.rg = 8'hFF; r.dt = 8'h00;
            pending_q.push_back(r);
            r.rtype = fmpw_pkg::REQ_FORCE;          // forced repeat still goes out
            pending_q.push_back(r);
            r.rtype = fmpw_pkg::REQ_RAW; r.rg = 8'hB5; r.dt = 8'h00;
            pending_q.push_back(r);
        end
        wait_drain();

        // drum channels and export mode at the extremes
        set_config(fmpw_pkg::CFG_DRUM_MASK, 9'h1FF);
        set_config(fmpw_pkg::CFG_EXPORT_MODE, 1'b1);
        pending_q.push_back(make_req(fmpw_pkg::REQ_NOTE_ON, 4'd5, 8'd100, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_NOTE_ON, 4'd5, 8'd100, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_SET_PITCH, 4'd6, 8'd0, 8'd0));
        pending_q.push_back(make_req(fmpw_pkg::REQ_DETUNED_ON, 4'd7, 8'd0, 8'h40));
        pending_q.push_back(make_req(fmpw_pkg::REQ_FINE_PITCH, 4'd7, 8'd0, 8'h10));

        // long receiver hold-off so the block backs up
        hold_request = 1'b1;
        for (int i = 0; i < 20; i++) pending_q.push_back(rand_req());
        wait_drain();
        hold_request = 1'b0;

        // random phases over several settings
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    set_config(fmpw_pkg::CFG_DRUM_MASK, 9'h000);
                    set_config(fmpw_pkg::CFG_EXPORT_MODE, 1'b0);
                end
                1:
                begin
                    set_config(fmpw_pkg::CFG_DRUM_MASK, 9'($urandom));
                    set_config(fmpw_pkg::CFG_EXPORT_MODE, 1'b1);
                end
                2:
                begin
                    set_config(fmpw_pkg::CFG_DRUM_MASK, 9'h1FF);
                    set_config(fmpw_pkg::CFG_EXPORT_MODE, 1'b0);
                end
                3: begin set_config(fmpw_pkg::CFG_DRUM_MASK, 9'h155); end
                4:
                begin
                    set_config(fmpw_pkg::CFG_DRUM_MASK, 9'h0AA);
                    set_config(fmpw_pkg::CFG_EXPORT_MODE, 1'b1);
                end
                default: begin set_config(fmpw_pkg::CFG_DRUM_MASK, 9'h000); calm = 1'b1; end
            endcase
            for (int i = 0; i < 185; i++) pending_q.push_back(rand_req());
            wait_drain();
        end

        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
